// ===== sv/assert_macros.svh =====
// assert_macros.svh: assertion macros shared by the RTL of the IMU smoothing block.
// Stand-alone header; no dependencies. Macros expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// next-cycle implication, disabled in reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/ibems_pkg.sv =====
// ibems_pkg: widths, constants, FSM state and control structs of the IMU smoothing block.
// No dependencies; used by the interfaces and every module.
package ibems_pkg;

  localparam int AXES  = 3;
  localparam int LANES = 2 * AXES;

  // field widths
  localparam int RAW_W   = 16;
  localparam int OUT_W   = 24;
  localparam int ALPHA_W = 17;
  localparam int CAL_W   = 16;
  localparam int CFG_W   = 17;

  // datapath widths
  localparam int SUM_W = 32;          // gyro bias sums
  localparam int NUM_W = SUM_W + 8;   // |sum| * 256 + count/2
  localparam int OFF_W = 24;          // bias, Q.8
  localparam int SV_W  = 32;          // smoothed value, Q.16
  localparam int X_W   = 34;          // new sample in Q.16
  localparam int D_W   = 35;          // sample minus smoothed value
  localparam int ACC_W = 52;          // alpha * difference
  localparam int N_W   = 37;          // updated value before saturation
  localparam int CNT_W = 5;
  localparam int SCORE_SUM_W = 26;

  // configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL   = 1'b1;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd13107;
  localparam logic [CAL_W-1:0]   CAL_RST   = 16'd64;
  localparam logic [CAL_W-1:0]   CAL_MAX   = 16'hFFFF;

  // serial step counts, counted down to zero
  localparam logic [CNT_W-1:0] DIV_LAST_CNT = CNT_W'(OFF_W - 1);
  localparam logic [CNT_W-1:0] MUL_LAST_CNT = CNT_W'(ALPHA_W - 1);

  // rounding and saturation constants
  localparam logic [ACC_W-1:0] EMA_HALF = ACC_W'(32768);
  localparam logic [SV_W:0]    OUT_HALF = (SV_W + 1)'(128);
  localparam logic [SV_W-1:0]  SV_MAX   = {1'b0, {(SV_W - 1){1'b1}}};
  localparam logic [SV_W-1:0]  SV_MIN   = {1'b1, {(SV_W - 1){1'b0}}};
  localparam logic [OUT_W-1:0] OUT_MAX  = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN  = {1'b1, {(OUT_W - 1){1'b0}}};

  // divide by three: floor(v * DIV3_MULT / 2^DIV3_SHIFT) is exact for v < 2^27
  localparam int DIV3_SHIFT = 27;
  localparam logic [SCORE_SUM_W-1:0] DIV3_MULT = 26'd44739243;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_COMMIT,
    ST_SUM,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
  } div_ctl_t;

  typedef struct packed {
    logic load;
    logic step;
    logic abit;
    logic commit;
    logic seed;
  } lane_ctl_t;

endpackage

// ===== sv/ibems_in_if.sv =====
// ibems_in_if: valid/ready channel carrying one raw 6-axis IMU sample.
// Depends on ibems_pkg for field widths.
interface ibems_in_if;
  logic valid;
  logic ready;
  logic signed [ibems_pkg::RAW_W-1:0] accel_x;
  logic signed [ibems_pkg::RAW_W-1:0] accel_y;
  logic signed [ibems_pkg::RAW_W-1:0] accel_z;
  logic signed [ibems_pkg::RAW_W-1:0] gyro_x;
  logic signed [ibems_pkg::RAW_W-1:0] gyro_y;
  logic signed [ibems_pkg::RAW_W-1:0] gyro_z;

  modport source (
    output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
    input  ready
  );
  modport sink (
    input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
    output ready
  );
endinterface

// ===== sv/ibems_out_if.sv =====
// ibems_out_if: valid/ready channel carrying smoothed IMU values and the motion score.
// Depends on ibems_pkg for field widths.
interface ibems_out_if;
  logic valid;
  logic ready;
  logic signed [ibems_pkg::OUT_W-1:0] smooth_accel_x;
  logic signed [ibems_pkg::OUT_W-1:0] smooth_accel_y;
  logic signed [ibems_pkg::OUT_W-1:0] smooth_accel_z;
  logic signed [ibems_pkg::OUT_W-1:0] smooth_gyro_x;
  logic signed [ibems_pkg::OUT_W-1:0] smooth_gyro_y;
  logic signed [ibems_pkg::OUT_W-1:0] smooth_gyro_z;
  logic [ibems_pkg::OUT_W-1:0]        motion_score;

  modport source (
    output valid, smooth_accel_x, smooth_accel_y, smooth_accel_z,
           smooth_gyro_x, smooth_gyro_y, smooth_gyro_z, motion_score,
    input  ready
  );
  modport sink (
    input  valid, smooth_accel_x, smooth_accel_y, smooth_accel_z,
           smooth_gyro_x, smooth_gyro_y, smooth_gyro_z, motion_score,
    output ready
  );
endinterface

// ===== sv/ibems_div.sv =====
// ibems_div: bit-serial rounding divider producing one gyro bias, Q.8, from sum and count.
// Depends on ibems_pkg. One quotient bit per step, OFF_W steps.
module ibems_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ibems_pkg::div_ctl_t                 ctl,
  input  logic signed [ibems_pkg::SUM_W-1:0]  sum,
  input  logic [ibems_pkg::CAL_W-1:0]         count,
  output logic signed [ibems_pkg::OFF_W-1:0]  offset
);

  logic                              neg_r;
  logic [ibems_pkg::OFF_W-1:0]       q_r;
  logic [ibems_pkg::CAL_W-1:0]       rem_r;
  logic [ibems_pkg::OFF_W-1:0]       dsr_r;
  logic [ibems_pkg::SUM_W-1:0]       sum_u;
  logic [ibems_pkg::SUM_W-1:0]       sum_mag;
  logic [ibems_pkg::NUM_W-1:0]       num_mag;
  logic [ibems_pkg::CAL_W:0]         rem2;
  logic [ibems_pkg::CAL_W:0]         diff;
  logic                              ge;
  logic [ibems_pkg::CAL_W-1:0]       rem_nxt;

  // magnitude of sum*256 plus half the count: rounds ties away from zero
  always_comb begin
    sum_u   = sum;
    sum_mag = sum_u[ibems_pkg::SUM_W-1] ? (~sum_u + 1'b1) : sum_u;
    num_mag = {sum_mag, 8'h00} + ibems_pkg::NUM_W'(count >> 1);
  end

  // one restoring step; quotient stays below 2^24, so the top 16 bits start as remainder
  always_comb begin
    rem2    = {rem_r, dsr_r[ibems_pkg::OFF_W-1]};
    diff    = rem2 - {1'b0, count};
    ge      = (rem2 >= {1'b0, count});
    rem_nxt = ge ? diff[ibems_pkg::CAL_W-1:0] : rem2[ibems_pkg::CAL_W-1:0];
  end

  // quotient and sign hold the bias between calibration samples
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r <= 1'b0;
      q_r   <= '0;
    end else if (ctl.start) begin
      neg_r <= sum_u[ibems_pkg::SUM_W-1];
      q_r   <= '0;
    end else if (ctl.step) begin
      q_r   <= {q_r[ibems_pkg::OFF_W-2:0], ge};
    end
  end

  // partial remainder and dividend shift register
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= num_mag[ibems_pkg::NUM_W-1:ibems_pkg::OFF_W];
      dsr_r <= num_mag[ibems_pkg::OFF_W-1:0];
    end else if (ctl.step) begin
      rem_r <= rem_nxt;
      dsr_r <= {dsr_r[ibems_pkg::OFF_W-2:0], 1'b0};
    end
  end

  assign offset = neg_r ? (~q_r + 1'b1) : q_r;

endmodule

// ===== sv/ibems_lane.sv =====
// ibems_lane: one smoothed channel: serial alpha multiply, EMA update, output rounding.
// Depends on ibems_pkg. Alpha bits arrive MSB first, one per step.
module ibems_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ibems_pkg::lane_ctl_t                ctl,
  input  logic signed [ibems_pkg::X_W-1:0]    x,
  output logic signed [ibems_pkg::OUT_W-1:0]  s_out
);

  logic signed [ibems_pkg::SV_W-1:0]  s_r;
  logic [ibems_pkg::SV_W-1:0]         s_nxt;
  logic signed [ibems_pkg::D_W-1:0]   d_r;
  logic signed [ibems_pkg::ACC_W-1:0] acc_r;
  logic [ibems_pkg::ACC_W-1:0]        dext;
  logic [ibems_pkg::ACC_W-1:0]        rnd;
  logic [ibems_pkg::N_W-1:0]          n;
  logic [ibems_pkg::SV_W:0]           r;

  assign dext = {{(ibems_pkg::ACC_W - ibems_pkg::D_W){d_r[ibems_pkg::D_W-1]}}, d_r};

  // EMA update or seeding, saturated to the smoothed-value width
  always_comb begin
    rnd = acc_r + ibems_pkg::EMA_HALF;
    n   = {{(ibems_pkg::N_W - ibems_pkg::SV_W){s_r[ibems_pkg::SV_W-1]}}, s_r}
        + {rnd[ibems_pkg::ACC_W-1], rnd[ibems_pkg::ACC_W-1:16]};
    if (ctl.seed) begin
      if (&x[ibems_pkg::X_W-1:ibems_pkg::SV_W-1] || ~|x[ibems_pkg::X_W-1:ibems_pkg::SV_W-1]) begin
        s_nxt = x[ibems_pkg::SV_W-1:0];
      end else begin
        s_nxt = x[ibems_pkg::X_W-1] ? ibems_pkg::SV_MIN : ibems_pkg::SV_MAX;
      end
    end else begin
      if (&n[ibems_pkg::N_W-1:ibems_pkg::SV_W-1] || ~|n[ibems_pkg::N_W-1:ibems_pkg::SV_W-1]) begin
        s_nxt = n[ibems_pkg::SV_W-1:0];
      end else begin
        s_nxt = n[ibems_pkg::N_W-1] ? ibems_pkg::SV_MIN : ibems_pkg::SV_MAX;
      end
    end
  end

  // round Q.16 to Q.8 half up, saturate to 24 bits
  always_comb begin
    r = {s_r[ibems_pkg::SV_W-1], s_r} + ibems_pkg::OUT_HALF;
    if (r[ibems_pkg::SV_W] == r[ibems_pkg::SV_W-1]) begin
      s_out = r[ibems_pkg::SV_W-1:8];
    end else begin
      s_out = r[ibems_pkg::SV_W] ? ibems_pkg::OUT_MIN : ibems_pkg::OUT_MAX;
    end
  end

  // smoothed value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else if (ctl.commit) begin
      s_r <= s_nxt;
    end
  end

  // difference and shift-add product
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      d_r   <= {x[ibems_pkg::X_W-1], x}
             - {{(ibems_pkg::D_W - ibems_pkg::SV_W){s_r[ibems_pkg::SV_W-1]}}, s_r};
      acc_r <= '0;
    end else if (ctl.step) begin
      acc_r <= (acc_r <<< 1) + (ctl.abit ? dext : '0);
    end
  end

endmodule

// ===== sv/imu_bias_ema_motion_score_unit.sv =====
// imu_bias_ema_motion_score_unit: gyro bias calibration, EMA smoothing, motion score.
// While calibrating, an item passes the 24-step bias divider and then the 17-step alpha multiply,
// afterwards only the multiply; a new item is accepted only after the last result is loaded for output.
// Synchronous active-low reset restores register defaults, clears bias and smoothing state.
// Depends on ibems_pkg, ibems_in_if, ibems_out_if, ibems_div, ibems_lane, assert_macros.svh.
`include "assert_macros.svh"

module imu_bias_ema_motion_score_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  ibems_in_if.sink                             in_if,
  ibems_out_if.source                          out_if,
  input  logic                                 cfg_we,
  input  logic [ibems_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ibems_pkg::CFG_W-1:0]          cfg_wdata
);

  ibems_pkg::state_t                    state_r, state_nxt;
  logic [ibems_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [ibems_pkg::ALPHA_W-1:0]        alpha_r;
  logic [ibems_pkg::CAL_W-1:0]          cal_r;
  logic [ibems_pkg::ALPHA_W-1:0]        alpha_sr_r;
  logic [ibems_pkg::ALPHA_W-1:0]        alpha_eff;
  logic signed [ibems_pkg::RAW_W-1:0]   accel_r [ibems_pkg::AXES];
  logic signed [ibems_pkg::RAW_W-1:0]   gyro_r  [ibems_pkg::AXES];
  logic signed [ibems_pkg::RAW_W-1:0]   gyro_in [ibems_pkg::AXES];
  logic signed [ibems_pkg::SUM_W-1:0]   bias_sum_r [ibems_pkg::AXES];
  logic [ibems_pkg::CAL_W-1:0]          bias_count_r;
  logic [ibems_pkg::CAL_W-1:0]          count_inc;
  logic                                 bias_done_r;
  logic                                 calib_r;
  logic                                 seeded_r;
  logic signed [ibems_pkg::OFF_W-1:0]   gyro_off [ibems_pkg::AXES];
  logic signed [ibems_pkg::X_W-1:0]     x [ibems_pkg::LANES];
  logic signed [ibems_pkg::OUT_W-1:0]   s_out [ibems_pkg::LANES];
  logic [ibems_pkg::OUT_W-1:0]          abs_g [ibems_pkg::AXES];
  logic [ibems_pkg::SCORE_SUM_W-1:0]    score_sum_nxt;
  logic [ibems_pkg::SCORE_SUM_W-1:0]    score_sum_r;
  logic [2*ibems_pkg::SCORE_SUM_W-1:0]  score_prod;
  logic signed [ibems_pkg::OUT_W-1:0]   res_r [ibems_pkg::LANES];
  logic signed [ibems_pkg::OUT_W-1:0]   out_val_r [ibems_pkg::LANES];
  logic [ibems_pkg::OUT_W-1:0]          out_score_r;
  logic                                 out_valid_r;
  ibems_pkg::div_ctl_t                  div_ctl;
  ibems_pkg::lane_ctl_t                 lane_ctl;
  logic                                 load_alpha;
  logic                                 calib_clr;
  logic                                 out_load;
  logic                                 in_acc;
  logic                                 out_take;

  assign in_if.ready = (state_r == ibems_pkg::ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_take    = out_valid_r && out_if.ready;

  assign gyro_in[0] = in_if.gyro_x;
  assign gyro_in[1] = in_if.gyro_y;
  assign gyro_in[2] = in_if.gyro_z;

  assign alpha_eff = (alpha_r > ibems_pkg::ALPHA_ONE) ? ibems_pkg::ALPHA_ONE : alpha_r;
  assign count_inc = (bias_count_r == ibems_pkg::CAL_MAX) ? ibems_pkg::CAL_W'(1)
                                                           : bias_count_r + ibems_pkg::CAL_W'(1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ibems_pkg::ALPHA_RST;
      cal_r   <= ibems_pkg::CAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ibems_pkg::CFG_ALPHA: alpha_r <= cfg_wdata[ibems_pkg::ALPHA_W-1:0];
        ibems_pkg::CFG_CAL:   cal_r   <= cfg_wdata[ibems_pkg::CAL_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: bias division, serial multiply, commit, score, output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ibems_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    div_ctl    = '0;
    lane_ctl   = '0;
    load_alpha = 1'b0;
    calib_clr  = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ibems_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ibems_pkg::ST_PREP;
        end
      end
      ibems_pkg::ST_PREP: begin
        if (calib_r) begin
          div_ctl.start = 1'b1;
          cnt_nxt       = ibems_pkg::DIV_LAST_CNT;
          state_nxt     = ibems_pkg::ST_DIV;
        end else begin
          lane_ctl.load = 1'b1;
          load_alpha    = 1'b1;
          cnt_nxt       = ibems_pkg::MUL_LAST_CNT;
          state_nxt     = ibems_pkg::ST_MUL;
        end
      end
      ibems_pkg::ST_DIV: begin
        div_ctl.step = 1'b1;
        if (cnt_r == '0) begin
          calib_clr = 1'b1;
          state_nxt = ibems_pkg::ST_PREP;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ibems_pkg::ST_MUL: begin
        lane_ctl.step = 1'b1;
        lane_ctl.abit = alpha_sr_r[ibems_pkg::ALPHA_W-1];
        if (cnt_r == '0) begin
          state_nxt = ibems_pkg::ST_COMMIT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ibems_pkg::ST_COMMIT: begin
        lane_ctl.commit = 1'b1;
        lane_ctl.seed   = !seeded_r;
        state_nxt       = ibems_pkg::ST_SUM;
      end
      ibems_pkg::ST_SUM: begin
        state_nxt = ibems_pkg::ST_DRAIN;
      end
      ibems_pkg::ST_DRAIN: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = ibems_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ibems_pkg::ST_IDLE;
      end
    endcase
  end

  // calibration state, seeding flag, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_count_r <= '0;
      bias_done_r  <= 1'b0;
      calib_r      <= 1'b0;
      seeded_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int a = 0; a < ibems_pkg::AXES; a++) begin
        bias_sum_r[a] <= '0;
      end
    end else begin
      if (in_acc) begin
        if (!bias_done_r) begin
          for (int a = 0; a < ibems_pkg::AXES; a++) begin
            bias_sum_r[a] <= bias_sum_r[a]
                           + {{(ibems_pkg::SUM_W - ibems_pkg::RAW_W){gyro_in[a][ibems_pkg::RAW_W-1]}},
                              gyro_in[a]};
          end
          bias_count_r <= count_inc;
          bias_done_r  <= (count_inc >= cal_r);
          calib_r      <= 1'b1;
        end else begin
          calib_r <= 1'b0;
        end
      end else if (calib_clr) begin
        calib_r <= 1'b0;
      end
      if (lane_ctl.commit) begin
        seeded_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload, alpha shift register, result staging and output register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      accel_r[0] <= in_if.accel_x;
      accel_r[1] <= in_if.accel_y;
      accel_r[2] <= in_if.accel_z;
      for (int a = 0; a < ibems_pkg::AXES; a++) begin
        gyro_r[a] <= gyro_in[a];
      end
    end
    if (load_alpha) begin
      alpha_sr_r <= alpha_eff;
    end else if (lane_ctl.step) begin
      alpha_sr_r <= {alpha_sr_r[ibems_pkg::ALPHA_W-2:0], 1'b0};
    end
    if (state_r == ibems_pkg::ST_SUM) begin
      for (int l = 0; l < ibems_pkg::LANES; l++) begin
        res_r[l] <= s_out[l];
      end
      score_sum_r <= score_sum_nxt;
    end
    if (out_load) begin
      for (int l = 0; l < ibems_pkg::LANES; l++) begin
        out_val_r[l] <= res_r[l];
      end
      out_score_r <= score_prod[ibems_pkg::DIV3_SHIFT +: ibems_pkg::OUT_W];
    end
  end

  // per-axis bias dividers
  for (genvar a = 0; a < ibems_pkg::AXES; a++) begin : g_div
    ibems_div u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (div_ctl),
      .sum    (bias_sum_r[a]),
      .count  (bias_count_r),
      .offset (gyro_off[a])
    );
  end

  // new samples in Q.16: accel as is, gyro minus bias
  always_comb begin
    for (int a = 0; a < ibems_pkg::AXES; a++) begin
      x[a] = {{2{accel_r[a][ibems_pkg::RAW_W-1]}}, accel_r[a], 16'h0000};
      x[ibems_pkg::AXES + a] = {{2{gyro_r[a][ibems_pkg::RAW_W-1]}}, gyro_r[a], 16'h0000}
                             - {{2{gyro_off[a][ibems_pkg::OFF_W-1]}}, gyro_off[a], 8'h00};
    end
  end

  // smoothing lanes: accel x,y,z then gyro x,y,z
  for (genvar l = 0; l < ibems_pkg::LANES; l++) begin : g_lane
    ibems_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (lane_ctl),
      .x     (x[l]),
      .s_out (s_out[l])
    );
  end

  // motion score: sum of absolute gyro outputs plus one, then divide by three
  always_comb begin
    for (int a = 0; a < ibems_pkg::AXES; a++) begin
      abs_g[a] = s_out[ibems_pkg::AXES + a][ibems_pkg::OUT_W-1]
               ? ibems_pkg::OUT_W'(-s_out[ibems_pkg::AXES + a])
               : ibems_pkg::OUT_W'(s_out[ibems_pkg::AXES + a]);
    end
    score_sum_nxt = ibems_pkg::SCORE_SUM_W'(abs_g[0]) + ibems_pkg::SCORE_SUM_W'(abs_g[1])
                  + ibems_pkg::SCORE_SUM_W'(abs_g[2]) + ibems_pkg::SCORE_SUM_W'(1);
  end

  assign score_prod = {{ibems_pkg::SCORE_SUM_W{1'b0}}, score_sum_r}
                    * {{ibems_pkg::SCORE_SUM_W{1'b0}}, ibems_pkg::DIV3_MULT};

  // result channel
  assign out_if.valid          = out_valid_r;
  assign out_if.smooth_accel_x = out_val_r[0];
  assign out_if.smooth_accel_y = out_val_r[1];
  assign out_if.smooth_accel_z = out_val_r[2];
  assign out_if.smooth_gyro_x  = out_val_r[3];
  assign out_if.smooth_gyro_y  = out_val_r[4];
  assign out_if.smooth_gyro_z  = out_val_r[5];
  assign out_if.motion_score   = out_score_r;

  // checks
  `ASSERT_IMP(a_div_only_when_calib, clk, rst_n, state_r == ibems_pkg::ST_DIV, calib_r)
  `ASSERT_IMP(a_count_nonzero_when_done, clk, rst_n, bias_done_r, bias_count_r != '0)
  `ASSERT_NXT(a_seeded_after_commit, clk, rst_n, state_r == ibems_pkg::ST_COMMIT, seeded_r)
  `ASSERT_NXT(a_drain_waits, clk, rst_n, state_r == ibems_pkg::ST_DRAIN && out_valid_r && !out_if.ready, state_r == ibems_pkg::ST_DRAIN && out_valid_r)

endmodule

// ===== tb/tb_imu_bias_ema_motion_score_unit.sv =====
// tb_imu_bias_ema_motion_score_unit: self-checking testbench for the IMU smoothing block.
// Depends on ibems_pkg, ibems_in_if, ibems_out_if and imu_bias_ema_motion_score_unit.
// Predicts bias calibration, EMA smoothing and motion score per item; compares every result.
module tb_imu_bias_ema_motion_score_unit;
  import ibems_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_GAP     = 12;
  localparam int TAIL_CYCLES = 60;
  localparam int PRINT_LIMIT = 40;
  localparam int PHASE_ITEMS = 64;
  localparam logic [ALPHA_W-1:0] ALPHA_FULL = {ALPHA_W{1'b1}};

  localparam longint Q16_HI = 64'sd2147483647;
  localparam longint Q16_LO = -64'sd2147483648;
  localparam longint Q8_HI  = 64'sd8388607;
  localparam longint Q8_LO  = -64'sd8388608;

  typedef struct packed {
    logic signed [RAW_W-1:0] accel_x;
    logic signed [RAW_W-1:0] accel_y;
    logic signed [RAW_W-1:0] accel_z;
    logic signed [RAW_W-1:0] gyro_x;
    logic signed [RAW_W-1:0] gyro_y;
    logic signed [RAW_W-1:0] gyro_z;
  } imu_sample_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] smooth_accel_x;
    logic signed [OUT_W-1:0] smooth_accel_y;
    logic signed [OUT_W-1:0] smooth_accel_z;
    logic signed [OUT_W-1:0] smooth_gyro_x;
    logic signed [OUT_W-1:0] smooth_gyro_y;
    logic signed [OUT_W-1:0] smooth_gyro_z;
    logic [OUT_W-1:0]        motion_score;
  } imu_smooth_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  ibems_in_if  in_ch ();
  ibems_out_if out_ch ();

  imu_bias_ema_motion_score_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state: registers, calibration and smoothing
  logic [ALPHA_W-1:0] alpha_reg  = ALPHA_RST;
  logic [CAL_W-1:0]   cal_target = CAL_RST;
  int               gyro_sum [AXES];
  logic [CAL_W-1:0] cal_count;
  bit               cal_done;
  int               gyro_bias_q8 [AXES];
  int               ema_q16 [LANES];
  bit               ema_seeded;

  imu_smooth_t smooth_expect_q [$];
  int rest_level [LANES];
  bit tx_burst;
  bit rx_burst;
  int mismatches;
  int samples_sent;
  int results_checked;
  int reg_writes;
  int cycle_count;
  int cal_length;

  string lane_name [LANES+1] = '{"smooth_accel_x", "smooth_accel_y", "smooth_accel_z",
                                 "smooth_gyro_x", "smooth_gyro_y", "smooth_gyro_z",
                                 "motion_score"};

  initial begin
    for (int i = 0; i < AXES; i++) begin
      gyro_sum[i] = 0;
      gyro_bias_q8[i] = 0;
    end
    for (int i = 0; i < LANES; i++) begin
      ema_q16[i] = 0;
      rest_level[i] = 0;
    end
    cal_count = '0;
    cal_done = 1'b0;
    ema_seeded = 1'b0;
  end

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Regression FAIL");
    $finish;
  end

  // one line per mismatch, printing capped
  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("MISMATCH %s: got %h expected %h (result %0d, cycle %0d)",
               what, got, want, results_checked, cycle_count);
  endtask

  // predictor: advance calibration and smoothing by one sample, return the result
  function automatic imu_smooth_t predict_smooth(input imu_sample_t smp);
    longint raw [LANES];
    longint xq [LANES];
    longint outv [LANES];
    longint a, s, n, num, mag, q, o, score;
    imu_smooth_t r;
    raw[0] = longint'($signed(smp.accel_x));
    raw[1] = longint'($signed(smp.accel_y));
    raw[2] = longint'($signed(smp.accel_z));
    raw[3] = longint'($signed(smp.gyro_x));
    raw[4] = longint'($signed(smp.gyro_y));
    raw[5] = longint'($signed(smp.gyro_z));
    a = (alpha_reg > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_reg);

    // bias: running mean while calibrating, rounded away from zero on ties
    if (!cal_done) begin
      for (int i = 0; i < AXES; i++)
        gyro_sum[i] = gyro_sum[i] + int'(raw[AXES+i]);
      cal_count = cal_count + 1'b1;
      if (cal_count == '0)
        cal_count = 1;
      for (int i = 0; i < AXES; i++) begin
        num = longint'(gyro_sum[i]) * 256;
        mag = (num < 0) ? -num : num;
        q = (mag + longint'(cal_count) / 2) / longint'(cal_count);
        gyro_bias_q8[i] = (num < 0) ? -int'(q) : int'(q);
      end
      if (cal_count >= cal_target) begin
        cal_done = 1'b1;
        cal_length = cal_count;
      end
    end

    for (int i = 0; i < AXES; i++) begin
      xq[i] = raw[i] * 65536;
      xq[AXES+i] = raw[AXES+i] * 65536 - longint'(gyro_bias_q8[i]) * 256;
    end

    // seed or EMA update, saturated to 32 bits
    for (int i = 0; i < LANES; i++) begin
      s = ema_q16[i];
      if (!ema_seeded)
        n = xq[i];
      else
        n = s + ((a * (xq[i] - s) + 32768) >>> 16);
      if (n > Q16_HI) n = Q16_HI;
      if (n < Q16_LO) n = Q16_LO;
      ema_q16[i] = int'(n);
    end
    ema_seeded = 1'b1;

    // Q.16 to Q.8 with rounding and 24-bit saturation
    score = 0;
    for (int i = 0; i < LANES; i++) begin
      o = (longint'(ema_q16[i]) + 128) >>> 8;
      if (o > Q8_HI) o = Q8_HI;
      if (o < Q8_LO) o = Q8_LO;
      outv[i] = o;
      if (i >= AXES)
        score += (o < 0) ? -o : o;
    end
    r.smooth_accel_x = OUT_W'(outv[0]);
    r.smooth_accel_y = OUT_W'(outv[1]);
    r.smooth_accel_z = OUT_W'(outv[2]);
    r.smooth_gyro_x  = OUT_W'(outv[3]);
    r.smooth_gyro_y  = OUT_W'(outv[4]);
    r.smooth_gyro_z  = OUT_W'(outv[5]);
    r.motion_score   = OUT_W'((score + 1) / AXES);
    return r;
  endfunction

  function automatic imu_sample_t imu_sample(input int ax, ay, az, gx, gy, gz);
    imu_sample_t smp;
    smp.accel_x = RAW_W'(ax);
    smp.accel_y = RAW_W'(ay);
    smp.accel_z = RAW_W'(az);
    smp.gyro_x  = RAW_W'(gx);
    smp.gyro_y  = RAW_W'(gy);
    smp.gyro_z  = RAW_W'(gz);
    return smp;
  endfunction

  // mostly a reading near the rest level, sometimes an extreme or any value
  function automatic int rand_reading(input int centre);
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 1) ? 32767 : -32768;
      1, 2: v = int'($signed(RAW_W'($urandom)));
      default: begin
        v = centre + int'($urandom_range(0, 800)) - 400;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
    endcase
    return v;
  endfunction

  function automatic imu_sample_t random_sample();
    int v [LANES];
    for (int i = 0; i < LANES; i++)
      v[i] = rand_reading(rest_level[i]);
    return imu_sample(v[0], v[1], v[2], v[3], v[4], v[5]);
  endfunction

  task automatic pick_rest_levels();
    for (int i = 0; i < LANES; i++)
      rest_level[i] = int'($urandom_range(0, 60000)) - 30000;
  endtask

  // send one item after a random gap, none in burst phases; expectation is queued on accept
  task automatic send_sample(input imu_sample_t smp);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.accel_x <= smp.accel_x;
    in_ch.accel_y <= smp.accel_y;
    in_ch.accel_z <= smp.accel_z;
    in_ch.gyro_x  <= smp.gyro_x;
    in_ch.gyro_y  <= smp.gyro_y;
    in_ch.gyro_z  <= smp.gyro_z;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    smooth_expect_q.push_back(predict_smooth(smp));
    samples_sent++;
  endtask

  // stop sending and wait until every expected result is in
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (smooth_expect_q.size() != 0);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ALPHA: alpha_reg = ALPHA_W'(val);
      CFG_CAL:   cal_target = CAL_W'(val);
      default: ;
    endcase
    reg_writes++;
  endtask

  // result sink: random stall before each item, none in burst phases
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    imu_smooth_t want;
    logic [OUT_W-1:0] got_f [LANES+1];
    logic [OUT_W-1:0] want_f [LANES+1];
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (smooth_expect_q.size() == 0) begin
        report_mismatch("unexpected result", out_ch.motion_score, '0);
      end else begin
        want = smooth_expect_q.pop_front();
        got_f  = '{out_ch.smooth_accel_x, out_ch.smooth_accel_y, out_ch.smooth_accel_z,
                   out_ch.smooth_gyro_x, out_ch.smooth_gyro_y, out_ch.smooth_gyro_z,
                   out_ch.motion_score};
        want_f = '{want.smooth_accel_x, want.smooth_accel_y, want.smooth_accel_z,
                   want.smooth_gyro_x, want.smooth_gyro_y, want.smooth_gyro_z,
                   want.motion_score};
        for (int i = 0; i <= LANES; i++)
          if (got_f[i] !== want_f[i])
            report_mismatch(lane_name[i], got_f[i], want_f[i]);
        results_checked++;
      end
    end
  end

  // field extremes under reset register values, calibration running
  task automatic test_reset_defaults();
    send_sample(imu_sample(0, 0, 0, 0, 0, 0));
    send_sample(imu_sample(32767, 32767, 32767, 32767, 32767, 32767));
    send_sample(imu_sample(-32768, -32768, -32768, -32768, -32768, -32768));
    send_sample(imu_sample(32767, -32768, 1, -32768, 32767, -1));
    send_sample(imu_sample(-1, 0, -32768, 1, -1, 32767));
    send_sample(imu_sample(21845, -21846, 21845, -21846, 21845, -21846));
    send_sample(imu_sample(-21846, 21845, -21846, 21845, -21846, 21845));
    send_sample(imu_sample(-1, -1, -1, -1, -1, -1));
  endtask

  // count raised mid-calibration, long calibration, then zero count closes it
  task automatic test_calibration_window();
    drain_results();
    write_reg(CFG_ALPHA, ALPHA_ONE);
    write_reg(CFG_CAL, CAL_MAX);
    pick_rest_levels();
    rest_level[AXES]   = 25000;
    rest_level[AXES+1] = -25000;
    repeat (60) send_sample(random_sample());
    drain_results();
    write_reg(CFG_CAL, 0);
    send_sample(imu_sample(100, -100, 16384, 25000, -25000, 0));
    // large bias against opposite extremes saturates the gyro x and y lanes
    send_sample(imu_sample(32767, -32768, 0, -32768, 32767, -32768));
  endtask

  // zero alpha holds, alpha past one acts as one, smallest step
  task automatic test_alpha_extremes();
    drain_results();
    write_reg(CFG_ALPHA, 0);
    send_sample(imu_sample(-32768, 32767, -32768, 32767, -32768, 32767));
    send_sample(imu_sample(0, 0, 0, 0, 0, 0));
    drain_results();
    write_reg(CFG_ALPHA, ALPHA_FULL);
    send_sample(imu_sample(32767, 32767, 32767, -32768, -32768, -32768));
    send_sample(imu_sample(-32768, 0, 32767, 32767, 32767, 32767));
    drain_results();
    write_reg(CFG_ALPHA, ALPHA_ONE + 1);
    send_sample(imu_sample(1, -1, 2, -2, 3, -3));
    drain_results();
    write_reg(CFG_ALPHA, 1);
    send_sample(imu_sample(32767, -32768, 32767, -32768, 32767, -32768));
    send_sample(imu_sample(-32768, 32767, -32768, 32767, -32768, 32767));
    drain_results();
    write_reg(CFG_CAL, 1);
  endtask

  // phases of random samples around fresh rest levels, varied alpha and pacing
  task automatic test_random_traffic();
    int unsigned alpha_val;
    int unsigned cal_val;
    for (int phase = 0; phase < 9; phase++) begin
      drain_results();
      case (phase)
        0: alpha_val = 1;
        1: alpha_val = ALPHA_ONE;
        2: alpha_val = ALPHA_FULL;
        3: alpha_val = 0;
        8: alpha_val = $urandom_range(0, ALPHA_FULL);
        default: alpha_val = $urandom_range(1, ALPHA_ONE);
      endcase
      case (phase)
        4: cal_val = CAL_MAX;
        5: cal_val = 0;
        6: cal_val = 1;
        default: cal_val = $urandom_range(0, CAL_MAX);
      endcase
      write_reg(CFG_ALPHA, alpha_val);
      write_reg(CFG_CAL, cal_val);
      tx_burst = (phase == 2) || (phase == 6);
      rx_burst = (phase == 2) || (phase == 5);
      pick_rest_levels();
      repeat (PHASE_ITEMS) send_sample(random_sample());
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // stimulus
  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_ALPHA;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.accel_x <= '0;
    in_ch.accel_y <= '0;
    in_ch.accel_z <= '0;
    in_ch.gyro_x  <= '0;
    in_ch.gyro_y  <= '0;
    in_ch.gyro_z  <= '0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    mismatches = 0;
    samples_sent = 0;
    results_checked = 0;
    reg_writes = 0;
    cal_length = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_calibration_window();
    test_alpha_extremes();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (smooth_expect_q.size() != 0)
      report_mismatch("results missing at end", '0, OUT_W'(smooth_expect_q.size()));

    $display("Sent %0d IMU samples, checked %0d smoothed results in %0d cycles.",
             samples_sent, results_checked, cycle_count);
    $display("Gyro bias closed after %0d samples; %0d register writes, alpha 0 to 0x%h.",
             cal_length, reg_writes, ALPHA_FULL);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
